// ----- design/xebs_pkg.sv -----
// Shared types, codes and prefix tables for the XML element boundary scanner.
// No dependencies; used by xebs_step and xml_element_boundary_scanner_unit.
package xebs_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LINE_W = 32;

  typedef enum logic [1:0] {
    CLASS_PLAIN   = 2'd0,
    CLASS_COMMENT = 2'd1,
    CLASS_CDATA   = 2'd2,
    CLASS_DOCTYPE = 2'd3
  } markup_class_t;

  typedef enum logic [2:0] {
    KIND_LITERAL = 3'd0,
    KIND_TAG     = 3'd1,
    KIND_COMMENT = 3'd2,
    KIND_CDATA   = 3'd3,
    KIND_DOCTYPE = 3'd4
  } element_kind_t;

  typedef enum logic [1:0] {
    QUOTE_NONE   = 2'd0,
    QUOTE_DOUBLE = 2'd1,
    QUOTE_SINGLE = 2'd2
  } quote_t;

  // Bit positions in the live prefix candidate set.
  localparam int unsigned CAND_COMMENT = 0;
  localparam int unsigned CAND_CDATA   = 1;
  localparam int unsigned CAND_DOCTYPE = 2;

  localparam logic [BYTE_W-1:0] CH_LT     = 8'h3C;
  localparam logic [BYTE_W-1:0] CH_GT     = 8'h3E;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_SQUOTE = 8'h27;
  localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_RBRACK = 8'h5D;

  localparam logic [15:0] MARK_COMMENT = 16'h2D2D;
  localparam logic [15:0] MARK_CDATA   = 16'h5D5D;

  localparam logic signed [7:0] DEPTH_MAX = 8'sh7F;
  localparam logic signed [7:0] DEPTH_MIN = -8'sd128;

  typedef struct packed {
    logic                in_markup;
    markup_class_t       markup_class;
    logic [3:0]          prefix_position;
    logic [2:0]          prefix_candidates;
    quote_t              open_quote;
    logic signed [7:0]   bracket_depth;
    logic [15:0]         previous_two_bytes;
    logic [LINE_W-1:0]   line_counter;
  } scan_state_t;

  localparam scan_state_t STATE_RESET = '{
    in_markup:          1'b0,
    markup_class:       CLASS_PLAIN,
    prefix_position:    4'd0,
    prefix_candidates:  3'b111,
    open_quote:         QUOTE_NONE,
    bracket_depth:      8'sd0,
    previous_two_bytes: 16'h0000,
    line_counter:       {{(LINE_W-1){1'b0}}, 1'b1}
  };

  typedef struct packed {
    logic [BYTE_W-1:0] byte_out;
    logic              inside_markup;
    logic              element_start;
    logic              markup_end;
    element_kind_t     element_kind;
    logic [LINE_W-1:0] line_number;
    logic              unclosed;
    logic              final_result;
  } scan_result_t;

  function automatic logic [BYTE_W-1:0] comment_char(input logic [1:0] idx);
    logic [BYTE_W-1:0] ch;
    unique case (idx)
      2'd0:    ch = 8'h21;
      default: ch = 8'h2D;
    endcase
    return ch;
  endfunction

  function automatic logic [BYTE_W-1:0] cdata_char(input logic [2:0] idx);
    logic [BYTE_W-1:0] ch;
    unique case (idx)
      3'd0: ch = 8'h21;
      3'd1: ch = 8'h5B;
      3'd2: ch = 8'h43;
      3'd3: ch = 8'h44;
      3'd4: ch = 8'h41;
      3'd5: ch = 8'h54;
      3'd6: ch = 8'h41;
      3'd7: ch = 8'h5B;
    endcase
    return ch;
  endfunction

  // Lower-case form of "!DOCTYPE".
  function automatic logic [BYTE_W-1:0] doctype_char(input logic [2:0] idx);
    logic [BYTE_W-1:0] ch;
    unique case (idx)
      3'd0: ch = 8'h21;
      3'd1: ch = 8'h64;
      3'd2: ch = 8'h6F;
      3'd3: ch = 8'h63;
      3'd4: ch = 8'h74;
      3'd5: ch = 8'h79;
      3'd6: ch = 8'h70;
      3'd7: ch = 8'h65;
    endcase
    return ch;
  endfunction

  function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  function automatic logic is_blank(input logic [BYTE_W-1:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D || c == 8'h0B
        || c == 8'h0C;
  endfunction

endpackage

// ----- design/xebs_step.sv -----
// Per-byte scan rule: next scanner state and the result for one byte.
// Depends on xebs_pkg.
module xebs_step (
  input  xebs_pkg::scan_state_t       st,
  input  logic [7:0]                  data_byte,
  input  logic                        end_of_stream,
  output xebs_pkg::scan_state_t       st_next,
  output xebs_pkg::scan_result_t      res
);
  import xebs_pkg::*;

  always_comb begin
    scan_state_t       nxt;
    logic [2:0]        live;
    markup_class_t     sel;
    logic              sel_hit;
    logic              proceed;
    logic              closes;
    logic              start;
    quote_t            q;
    logic [3:0]        p;
    logic [15:0]       mark;
    element_kind_t     kind;

    nxt     = st;
    live    = 3'b000;
    sel     = CLASS_PLAIN;
    sel_hit = 1'b0;
    proceed = 1'b1;
    closes  = 1'b0;
    start   = 1'b0;
    q       = QUOTE_NONE;
    p       = st.prefix_position;
    mark    = MARK_COMMENT;
    kind    = KIND_LITERAL;

    if (data_byte == CH_LF && st.line_counter != {LINE_W{1'b1}}) begin
      nxt.line_counter = st.line_counter + 1'b1;
    end

    if (!st.in_markup) begin
      if (data_byte == CH_LT) begin
        nxt = STATE_RESET;
        nxt.line_counter = (data_byte == CH_LF) ? nxt.line_counter : st.line_counter;
        nxt.in_markup = 1'b1;
        start = 1'b1;
        kind  = KIND_TAG;
      end else begin
        start = (st.prefix_position == 4'd0);
        nxt.prefix_position = 4'd1;
        kind  = KIND_LITERAL;
      end
    end else begin
      // Prefix detection right after the '<'.
      if (st.markup_class == CLASS_PLAIN && st.prefix_candidates != 3'b000) begin
        if (st.prefix_candidates[CAND_COMMENT] && p < 4'd3
            && data_byte == comment_char(p[1:0])) begin
          live[CAND_COMMENT] = 1'b1;
          if (p == 4'd2) begin
            sel = CLASS_COMMENT;
            sel_hit = 1'b1;
          end
        end
        if (st.prefix_candidates[CAND_CDATA] && p < 4'd8
            && data_byte == cdata_char(p[2:0])) begin
          live[CAND_CDATA] = 1'b1;
          if (p == 4'd7) begin
            sel = CLASS_CDATA;
            sel_hit = 1'b1;
          end
        end
        if (st.prefix_candidates[CAND_DOCTYPE]) begin
          if (p < 4'd8 && fold_case(data_byte) == doctype_char(p[2:0])) begin
            live[CAND_DOCTYPE] = 1'b1;
          end else if (p == 4'd8 && (is_blank(data_byte) || data_byte == CH_GT)) begin
            sel = CLASS_DOCTYPE;
            sel_hit = 1'b1;
          end
        end
        if (sel_hit) begin
          nxt.markup_class       = sel;
          nxt.prefix_candidates  = 3'b000;
          nxt.prefix_position    = 4'd0;
          nxt.previous_two_bytes = 16'h0000;
          if (sel != CLASS_DOCTYPE) begin
            proceed = 1'b0;
          end
        end else if (live != 3'b000) begin
          nxt.prefix_candidates = live;
          nxt.prefix_position   = p + 4'd1;
          proceed = 1'b0;
        end else begin
          nxt.prefix_candidates = 3'b000;
        end
      end

      if (proceed) begin
        unique case (nxt.markup_class)
          CLASS_PLAIN: begin
            if (data_byte == CH_DQUOTE) begin
              q = QUOTE_DOUBLE;
            end else if (data_byte == CH_SQUOTE) begin
              q = QUOTE_SINGLE;
            end
            if (nxt.open_quote == QUOTE_NONE) begin
              nxt.open_quote = q;
            end else if (nxt.open_quote == q) begin
              nxt.open_quote = QUOTE_NONE;
            end
            closes = (data_byte == CH_GT) && (nxt.open_quote == QUOTE_NONE);
          end
          CLASS_COMMENT, CLASS_CDATA: begin
            mark = (nxt.markup_class == CLASS_COMMENT) ? MARK_COMMENT : MARK_CDATA;
            if (data_byte == CH_GT && nxt.prefix_position >= 4'd2
                && nxt.previous_two_bytes == mark) begin
              closes = 1'b1;
            end else begin
              nxt.previous_two_bytes = {nxt.previous_two_bytes[7:0], data_byte};
              if (nxt.prefix_position != 4'd15) begin
                nxt.prefix_position = nxt.prefix_position + 4'd1;
              end
            end
          end
          CLASS_DOCTYPE: begin
            if (data_byte == CH_GT) begin
              closes = (nxt.bracket_depth == 8'sd0);
            end else if (data_byte == CH_LBRACK && nxt.bracket_depth != DEPTH_MAX) begin
              nxt.bracket_depth = nxt.bracket_depth + 8'sd1;
            end else if (data_byte == CH_RBRACK && nxt.bracket_depth != DEPTH_MIN) begin
              nxt.bracket_depth = nxt.bracket_depth - 8'sd1;
            end
          end
        endcase
      end

      kind = element_kind_t'({1'b0, nxt.markup_class} + 3'd1);
      if (closes) begin
        nxt.markup_class       = CLASS_PLAIN;
        nxt.prefix_position    = 4'd0;
        nxt.prefix_candidates  = STATE_RESET.prefix_candidates;
        nxt.open_quote         = QUOTE_NONE;
        nxt.bracket_depth      = 8'sd0;
        nxt.previous_two_bytes = 16'h0000;
        nxt.in_markup          = 1'b0;
      end
    end

    res.byte_out      = data_byte;
    res.inside_markup = st.in_markup || (data_byte == CH_LT);
    res.element_start = start;
    res.markup_end    = closes;
    res.element_kind  = kind;
    res.line_number   = st.line_counter;
    res.unclosed      = end_of_stream && nxt.in_markup;
    res.final_result  = end_of_stream;

    st_next = end_of_stream ? STATE_RESET : nxt;
  end

endmodule

// ----- design/xml_element_boundary_scanner_unit.sv -----
// Top level of the XML element boundary scanner: state and result registers.
// Depends on xebs_pkg and xebs_step.
//
// Usage
//   The block takes one raw XML byte per word on the input channel
//   (in_valid/in_ready, payload data_byte and end_of_stream) and gives one
//   result word per byte on the output channel (out_valid/out_ready). Each
//   result carries the byte, whether it belongs to markup, start and end
//   marks of the element, its kind as known after that byte, the line on
//   which the byte stands, and on the final byte the unclosed flag.
//   The result of an accepted byte is offered in the cycle after it is
//   accepted. Throughput is one byte per cycle while the receiver takes
//   each result; the figure is set by the scanner state register, which
//   the per-byte rule reads and writes in the same cycle.
//   The result register decouples the two sides: a new byte is accepted
//   whenever the result register is empty or its word is taken in the same
//   cycle. If the receiver stalls, the result is held and input stops after
//   one byte; nothing is dropped or repeated.
//   Reset returns the scanner to text mode at line 1 and empties the result
//   register. A byte marked as end of stream returns the state to the same
//   values, so the next byte starts a fresh document.
module xml_element_boundary_scanner_unit (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              data_byte,
  input  logic                    end_of_stream,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [7:0]              byte_out,
  output logic                    inside_markup,
  output logic                    element_start,
  output logic                    markup_end,
  output logic [2:0]              element_kind,
  output logic [31:0]             line_number,
  output logic                    unclosed,
  output logic                    final_result
);
  import xebs_pkg::*;

  scan_state_t  st;
  scan_state_t  st_next;
  scan_result_t res_next;
  scan_result_t res;
  logic         in_fire;

  // The result register may be refilled in the cycle its word is taken.
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  xebs_step u_step (
    .st            (st),
    .data_byte     (data_byte),
    .end_of_stream (end_of_stream),
    .st_next       (st_next),
    .res           (res_next)
  );

  // Scanner state advances only on an accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= STATE_RESET;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        st <= st_next;
      end
      if (in_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload of the result register needs no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res <= res_next;
    end
  end

  assign byte_out      = res.byte_out;
  assign inside_markup = res.inside_markup;
  assign element_start = res.element_start;
  assign markup_end    = res.markup_end;
  assign element_kind  = res.element_kind;
  assign line_number   = res.line_number;
  assign unclosed      = res.unclosed;
  assign final_result  = res.final_result;

  // A closing mark only ever falls on a '>' inside markup.
  a_end_on_gt: assert property (@(posedge clk) disable iff (rst)
    out_valid && markup_end |-> inside_markup && byte_out == CH_GT)
    else $error("markup end on a byte other than a closing bracket");

  // An unclosed flag only comes with the final byte of markup.
  a_unclosed_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && unclosed |-> final_result && inside_markup && !markup_end)
    else $error("unclosed flag outside the final markup byte");

  // After the final byte the scanner is back in text mode at line 1.
  a_eos_clears: assert property (@(posedge clk) disable iff (rst)
    in_fire && end_of_stream |=> !st.in_markup && st.line_counter == 32'd1)
    else $error("state not cleared after end of stream");

  // Literal bytes are never reported as markup.
  a_literal_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && element_kind == KIND_LITERAL |-> !inside_markup)
    else $error("literal kind on a markup byte");

endmodule
